// ===== design/harsh_event_detect_and_score_macros.svh =====
// Assertion macros shared by the harsh event detector modules.
`ifndef HARSH_EVENT_DETECT_AND_SCORE_MACROS_SVH
`define HARSH_EVENT_DETECT_AND_SCORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/hedsc_pkg.sv =====
// Shared types, codes and constants of the harsh event detector.
package hedsc_pkg;

  // Item kinds carried in tuser.
  localparam int KIND_W = 2;
  localparam logic [KIND_W-1:0] KIND_SAMPLE    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EVENT     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RECOMPUTE = 2'd2;
  localparam logic [KIND_W-1:0] KIND_NOP       = 2'd3;

  // External event types.
  localparam int EVT_W = 3;
  localparam logic [EVT_W-1:0] EVT_BRAKE    = 3'd0;
  localparam logic [EVT_W-1:0] EVT_ACCEL    = 3'd1;
  localparam logic [EVT_W-1:0] EVT_CORNER   = 3'd2;
  localparam logic [EVT_W-1:0] EVT_OVER     = 3'd3;
  localparam logic [EVT_W-1:0] EVT_IDLING   = 3'd4;
  localparam logic [EVT_W-1:0] EVT_CRASH    = 3'd5;
  localparam logic [EVT_W-1:0] EVT_GEOFENCE = 3'd6;
  localparam logic [EVT_W-1:0] EVT_UNKNOWN  = 3'd7;

  // Configuration register indexes (byte address is four times the index).
  localparam int PADDR_W = 4;
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_BRAKE_THR  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ACCEL_THR  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CORNER_THR = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_OVER_THR   = 2'd3;
  localparam int APB_DATA_W = 32;

  // Field widths.
  localparam int THR_W = 14;
  localparam int SPD_W = 12;
  localparam int ACC_W = 15;
  localparam int SECS_W = 16;
  localparam int COND_W = 4;
  localparam int SCORE_W = 14;
  localparam int OUT_CNT_W = 16;
  localparam int OUT_IDLE_W = 32;

  // Threshold reset values.
  localparam logic [THR_W-1:0] BRAKE_THR_RST  = 14'd400;
  localparam logic [THR_W-1:0] ACCEL_THR_RST  = 14'd400;
  localparam logic [THR_W-1:0] CORNER_THR_RST = 14'd400;
  localparam logic [SPD_W-1:0] OVER_THR_RST   = 12'd1200;

  // Input word layout, lowest field first.
  localparam int LONG_LSB = 0;
  localparam int LAT_LSB = LONG_LSB + ACC_W;
  localparam int PVAL_BIT = LAT_LSB + ACC_W;
  localparam int PSPD_LSB = PVAL_BIT + 1;
  localparam int BVAL_BIT = PSPD_LSB + SPD_W;
  localparam int BSPD_LSB = BVAL_BIT + 1;
  localparam int EVT_LSB = BSPD_LSB + SPD_W;
  localparam int SECS_LSB = EVT_LSB + EVT_W;
  localparam int IN_USED_W = SECS_LSB + SECS_W;
  localparam int IN_DATA_W = ((IN_USED_W + 7) / 8) * 8;

  // Output word layout, lowest field first.
  localparam int NUM_CNT = 6;
  localparam int OUT_USED_W = SCORE_W + NUM_CNT * OUT_CNT_W + OUT_IDLE_W + COND_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;

  // Counter slots.
  localparam int CNT_BRAKE = 0;
  localparam int CNT_ACCEL = 1;
  localparam int CNT_CORNER = 2;
  localparam int CNT_OVER = 3;
  localparam int CNT_CRASH = 4;
  localparam int CNT_GEO = 5;

  // Score arithmetic. Any counter above CNT_CLAMP or idle total above
  // IDLE_CLAMP already pushes the penalty past the full score, so the
  // score path only ever sees narrow clamped values.
  localparam logic [SCORE_W-1:0] SCORE_FULL = 14'd10000;
  localparam int CLAMP_W = 7;
  localparam int CNT_CLAMP = 127;
  localparam int IDLE_CLAMP_W = 17;
  localparam int IDLE_CLAMP = 120000;
  localparam int QUO_IN_W = IDLE_CLAMP_W - 2;
  localparam int RECIP3 = 43691;
  localparam int RECIP_SHIFT = 17;
  localparam int RECIP_PROD_W = 32;
  localparam int TERM_W = 20;
  localparam int PEN_W = 22;
  localparam int unsigned CNT_WEIGHT [NUM_CNT] = '{200, 200, 150, 300, 5000, 500};

  // Parameter defaults.
  localparam int COUNT_WIDTH_DEF = 16;
  localparam int IDLE_WIDTH_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Classified item held in the queue.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [COND_W-1:0] cond;
    logic [EVT_W-1:0]  event_type;
    logic [SECS_W-1:0] idle_seconds;
  } op_t;

  // Item leaving the state stage toward the score stages.
  typedef struct packed {
    logic                                recompute;
    logic [NUM_CNT-1:0][OUT_CNT_W-1:0]   count;
    logic [OUT_IDLE_W-1:0]               idle_total;
    logic [COND_W-1:0]                   flags;
    logic [NUM_CNT-1:0][CLAMP_W-1:0]     count_clamp;
    logic [IDLE_CLAMP_W-1:0]             idle_clamp;
  } stage_t;

endpackage

// ===== design/harsh_event_detect_and_score.sv =====
// Top level of the harsh driving event detector and safety score block.
//
// Usage: words enter on the s_ stream; tuser selects the kind (sensor
// sample, external event, recompute score or no operation) and tdata holds
// the sample and event fields. Every accepted word gives exactly one result
// word on the m_ stream with the latched score, the six counters, the idle
// total and the newly detected condition flags. The user must write the
// thresholds on the APB-style port when idle; the block does not check.
// Throughput: one word per clock cycle, sustained while m_tready is high,
// including recompute. A word passes the queue write, the state stage and
// the two score stages (products, then sum) on its way to m_tvalid.
// Stall: when m_tready is low the pipeline holds its words and the queue
// fills; s_tready falls only when the four-word queue is full.
// Reset (synchronous, active high) empties the queue and pipeline, clears
// all counters, the idle total and the condition history, sets the score
// to 10000 and returns the thresholds to 400, 400, 400 mg and 120.0 km/h.
module harsh_event_detect_and_score
  import hedsc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int IDLE_WIDTH  = IDLE_WIDTH_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // Fields from bit 0: accel_long_mg, accel_lat_mg, primary_speed_valid,
  // primary_speed_dkmh, backup_speed_valid, backup_speed_dkmh, event_type,
  // idle_seconds, zero fill.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // Fields from bit 0: kind.
  input  logic [KIND_W-1:0]     s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // Fields from bit 0: score_centipoints, braking_count, accel_count,
  // cornering_count, speeding_count, collision_count, geofence_count,
  // idle_total_seconds, detected_flags, zero fill.
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic   q_full;
  logic   push;
  op_t    push_op;
  logic   q_valid;
  op_t    q_head;
  logic   pop;
  logic   a_valid;
  stage_t a_data;
  logic   a_ready;

  hedsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .push     (push),
    .push_op  (push_op)
  );

  hedsc_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .valid   (q_valid),
    .head    (q_head)
  );

  hedsc_back #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .IDLE_WIDTH  (IDLE_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_op       (q_head),
    .pop        (pop),
    .a_valid    (a_valid),
    .a_data     (a_data),
    .down_ready (a_ready)
  );

  hedsc_score u_score (
    .clk      (clk),
    .rst      (rst),
    .in_valid (a_valid),
    .in_ready (a_ready),
    .in_data  (a_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

// ===== design/hedsc_front.sv =====
// Front end: configuration registers, input handshake and condition checks.
module hedsc_front
  import hedsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic [KIND_W-1:0]     s_tuser,
  input  logic                  q_full,
  output logic                  push,
  output op_t                   push_op
);

  logic [THR_W-1:0] brake_thr;
  logic [THR_W-1:0] accel_thr;
  logic [THR_W-1:0] corner_thr;
  logic [SPD_W-1:0] over_thr;
  logic             wr_en;

  logic signed [ACC_W:0] along;
  logic signed [ACC_W:0] alat;
  logic signed [ACC_W:0] pos_bt;
  logic signed [ACC_W:0] pos_at;
  logic signed [ACC_W:0] pos_ct;
  logic signed [ACC_W:0] neg_bt;
  logic signed [ACC_W:0] neg_ct;
  logic                  pval;
  logic                  bval;
  logic [SPD_W-1:0]      speed;
  logic [COND_W-1:0]     cond;

  // Register writes complete on the access cycle.
  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      brake_thr  <= BRAKE_THR_RST;
      accel_thr  <= ACCEL_THR_RST;
      corner_thr <= CORNER_THR_RST;
      over_thr   <= OVER_THR_RST;
    end else if (wr_en) begin
      case (paddr[PADDR_W-1:2])
        REG_BRAKE_THR:  brake_thr  <= pwdata[THR_W-1:0];
        REG_ACCEL_THR:  accel_thr  <= pwdata[THR_W-1:0];
        REG_CORNER_THR: corner_thr <= pwdata[THR_W-1:0];
        REG_OVER_THR:   over_thr   <= pwdata[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_BRAKE_THR:  prdata = APB_DATA_W'(brake_thr);
      REG_ACCEL_THR:  prdata = APB_DATA_W'(accel_thr);
      REG_CORNER_THR: prdata = APB_DATA_W'(corner_thr);
      REG_OVER_THR:   prdata = APB_DATA_W'(over_thr);
      default:        prdata = '0;
    endcase
  end

  // Threshold checks; the mg compares are signed at one bit above the field.
  always_comb begin
    along  = $signed({s_tdata[LONG_LSB+ACC_W-1], s_tdata[LONG_LSB +: ACC_W]});
    alat   = $signed({s_tdata[LAT_LSB+ACC_W-1], s_tdata[LAT_LSB +: ACC_W]});
    pos_bt = $signed({{(ACC_W+1-THR_W){1'b0}}, brake_thr});
    pos_at = $signed({{(ACC_W+1-THR_W){1'b0}}, accel_thr});
    pos_ct = $signed({{(ACC_W+1-THR_W){1'b0}}, corner_thr});
    neg_bt = -pos_bt;
    neg_ct = -pos_ct;
    pval   = s_tdata[PVAL_BIT];
    bval   = s_tdata[BVAL_BIT];
    speed  = pval ? s_tdata[PSPD_LSB +: SPD_W] : s_tdata[BSPD_LSB +: SPD_W];
    cond[CNT_BRAKE]  = (along <= neg_bt);
    cond[CNT_ACCEL]  = (along >= pos_at);
    cond[CNT_CORNER] = (alat >= pos_ct) || (alat <= neg_ct);
    cond[CNT_OVER]   = (pval || bval) && (speed >= over_thr);
  end

  // Classified word into the queue.
  assign s_tready = !q_full;
  assign push = s_tvalid && s_tready;

  always_comb begin
    push_op.kind         = s_tuser;
    push_op.cond         = cond;
    push_op.event_type   = s_tdata[EVT_LSB +: EVT_W];
    push_op.idle_seconds = s_tdata[SECS_LSB +: SECS_W];
  end

endmodule

// ===== design/hedsc_queue.sv =====
// Short queue of classified words between the front end and the state stage.
`include "harsh_event_detect_and_score_macros.svh"
module hedsc_queue
  import hedsc_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  op_t  push_op,
  output logic full,
  input  logic pop,
  output logic valid,
  output op_t  head
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

  op_t           slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign full  = (count == (AW+1)'(QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `ASSERT_IMPLY(q_no_overflow, clk, rst, full, !push, "word pushed into a full queue")
  `ASSERT_IMPLY(q_no_underflow, clk, rst, pop, valid, "word popped from an empty queue")
  `ASSERT_NEXT(q_count_drop, clk, rst, pop && !push, count == (AW+1)'($past(count) - 1'b1), "queue count did not drop on a pop")

endmodule

// ===== design/hedsc_back.sv =====
// State stage: rising-edge detection, saturating counters and idle total.
`include "harsh_event_detect_and_score_macros.svh"
module hedsc_back
  import hedsc_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF,
  parameter int IDLE_WIDTH  = IDLE_WIDTH_DEF
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   q_valid,
  input  op_t    q_op,
  output logic   pop,
  output logic   a_valid,
  output stage_t a_data,
  input  logic   down_ready
);

  localparam int IW = (IDLE_WIDTH > IDLE_CLAMP_W) ? IDLE_WIDTH : IDLE_CLAMP_W;

  logic [NUM_CNT-1:0][COUNT_WIDTH-1:0] cnt;
  logic [NUM_CNT-1:0][COUNT_WIDTH-1:0] cnt_next;
  logic [IDLE_WIDTH-1:0]               idle;
  logic [IDLE_WIDTH-1:0]               idle_next;
  logic [IDLE_WIDTH:0]                 idle_sum;
  logic [IW-1:0]                       idle_wide;
  logic [COND_W-1:0]                   prev_cond;
  logic [COND_W-1:0]                   rise;
  logic [NUM_CNT-1:0]                  bump;
  logic                                idle_add;
  stage_t                              a_next;

  // Take the next word whenever the stage register is free or moving on.
  assign pop = q_valid && (!a_valid || down_ready);

  // Work out which counters move for this word.
  always_comb begin
    rise     = '0;
    bump     = '0;
    idle_add = 1'b0;
    case (q_op.kind)
      KIND_SAMPLE: begin
        rise = q_op.cond & ~prev_cond;
        bump[COND_W-1:0] = rise;
      end
      KIND_EVENT: begin
        case (q_op.event_type)
          EVT_BRAKE:    bump[CNT_BRAKE]  = 1'b1;
          EVT_ACCEL:    bump[CNT_ACCEL]  = 1'b1;
          EVT_CORNER:   bump[CNT_CORNER] = 1'b1;
          EVT_OVER:     bump[CNT_OVER]   = 1'b1;
          EVT_IDLING:   idle_add         = 1'b1;
          EVT_CRASH:    bump[CNT_CRASH]  = 1'b1;
          EVT_GEOFENCE: bump[CNT_GEO]    = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Saturating updates.
  always_comb begin
    for (int i = 0; i < NUM_CNT; i++) begin
      cnt_next[i] = (bump[i] && (cnt[i] != {COUNT_WIDTH{1'b1}})) ? cnt[i] + 1'b1 : cnt[i];
    end
    idle_sum  = {1'b0, idle} + (IDLE_WIDTH+1)'(q_op.idle_seconds);
    idle_next = idle;
    if (idle_add) begin
      idle_next = idle_sum[IDLE_WIDTH] ? {IDLE_WIDTH{1'b1}} : idle_sum[IDLE_WIDTH-1:0];
    end
  end

  // Result word for this item; clamped copies feed the score stages.
  always_comb begin
    idle_wide          = IW'(idle);
    a_next.recompute   = (q_op.kind == KIND_RECOMPUTE);
    a_next.idle_total  = OUT_IDLE_W'(idle_next);
    a_next.flags       = rise;
    for (int i = 0; i < NUM_CNT; i++) begin
      a_next.count[i]       = OUT_CNT_W'(cnt_next[i]);
      a_next.count_clamp[i] = (cnt[i] > COUNT_WIDTH'(CNT_CLAMP)) ?
                              CLAMP_W'(CNT_CLAMP) : CLAMP_W'(cnt[i]);
    end
    a_next.idle_clamp = (idle_wide > IW'(IDLE_CLAMP)) ?
                        IDLE_CLAMP_W'(IDLE_CLAMP) : IDLE_CLAMP_W'(idle_wide);
  end

  // Architectural state.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt       <= '0;
      idle      <= '0;
      prev_cond <= '0;
    end else if (pop) begin
      cnt  <= cnt_next;
      idle <= idle_next;
      if (q_op.kind == KIND_SAMPLE) begin
        prev_cond <= q_op.cond;
      end
    end
  end

  // Stage register toward the score stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pop) begin
      a_valid <= 1'b1;
    end else if (down_ready) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_data <= a_next;
    end
  end

  `ASSERT_NEXT(a_stall_hold, clk, rst, a_valid && !down_ready, a_valid && $stable(a_data), "stalled stage word changed")
  `ASSERT_NEXT(recompute_keeps_state, clk, rst, pop && (q_op.kind == KIND_RECOMPUTE), $stable(cnt) && $stable(idle), "recompute moved a counter")
  `ASSERT_NEXT(prev_only_on_sample, clk, rst, pop && (q_op.kind != KIND_SAMPLE), $stable(prev_cond), "condition history moved on a non-sample word")
  `ASSERT_NEXT(prev_follows_sample, clk, rst, pop && (q_op.kind == KIND_SAMPLE), prev_cond == $past(q_op.cond), "condition history missed a sample")

endmodule

// ===== design/hedsc_score.sv =====
// Score stages: weighted penalty, floor at zero, latched score and output register.
module hedsc_score
  import hedsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  stage_t                in_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic                             b_valid;
  stage_t                           b_stage;
  logic [NUM_CNT-1:0][TERM_W-1:0]   b_term;
  logic [SCORE_W-1:0]               b_idle_q;
  logic [NUM_CNT-1:0][TERM_W-1:0]   term;
  logic [RECIP_PROD_W-1:0]          recip_prod;
  logic [PEN_W-1:0]                 penalty;
  logic [SCORE_W-1:0]               new_score;
  logic [SCORE_W-1:0]               latched_score;
  logic                             c_ready;

  logic [SCORE_W-1:0]                  out_score;
  logic [NUM_CNT-1:0][OUT_CNT_W-1:0]   out_count;
  logic [OUT_IDLE_W-1:0]               out_idle;
  logic [COND_W-1:0]                   out_flags;

  assign c_ready  = !m_tvalid || m_tready;
  assign in_ready = !b_valid || c_ready;

  // First stage: constant-weight products and idle/12 by reciprocal.
  always_comb begin
    for (int i = 0; i < NUM_CNT; i++) begin
      term[i] = TERM_W'(in_data.count_clamp[i]) * TERM_W'(CNT_WEIGHT[i]);
    end
    recip_prod = RECIP_PROD_W'(in_data.idle_clamp[IDLE_CLAMP_W-1:2]) *
                 RECIP_PROD_W'(RECIP3);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      b_valid <= 1'b1;
    end else if (c_ready) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      b_stage  <= in_data;
      b_term   <= term;
      b_idle_q <= recip_prod[RECIP_SHIFT +: SCORE_W];
    end
  end

  // Second stage: recompute sums the penalty and floors the score at zero.
  always_comb begin
    penalty = PEN_W'(b_idle_q);
    for (int i = 0; i < NUM_CNT; i++) begin
      penalty = penalty + PEN_W'(b_term[i]);
    end
    if (!b_stage.recompute) begin
      new_score = latched_score;
    end else if (penalty >= PEN_W'(SCORE_FULL)) begin
      new_score = '0;
    end else begin
      new_score = SCORE_FULL - penalty[SCORE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid      <= 1'b0;
      latched_score <= SCORE_FULL;
    end else if (b_valid && c_ready) begin
      m_tvalid      <= 1'b1;
      latched_score <= new_score;
    end else if (c_ready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Output word register.
  always_ff @(posedge clk) begin
    if (b_valid && c_ready) begin
      out_score <= new_score;
      out_count <= b_stage.count;
      out_idle  <= b_stage.idle_total;
      out_flags <= b_stage.flags;
    end
  end

  assign m_tdata = OUT_DATA_W'({out_flags, out_idle, out_count, out_score});

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the harsh event detector and safety score block.
`timescale 1ns / 100ps

module tb;
  import hedsc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_HOLD = 60;

  // Input word fields, packed with the first field in the lowest bits.
  typedef struct packed {
    logic [SECS_W-1:0] idle_seconds;
    logic [EVT_W-1:0]  event_type;
    logic [SPD_W-1:0]  backup_speed;
    logic              backup_valid;
    logic [SPD_W-1:0]  primary_speed;
    logic              primary_valid;
    logic [ACC_W-1:0]  accel_lat;
    logic [ACC_W-1:0]  accel_long;
  } fields_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    fields_t           f;
  } word_t;

  // Result word fields, same packing as m_tdata.
  typedef struct packed {
    logic [COND_W-1:0]                 flags;
    logic [OUT_IDLE_W-1:0]             idle_total;
    logic [NUM_CNT-1:0][OUT_CNT_W-1:0] count;
    logic [SCORE_W-1:0]                score;
  } report_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // Fields from bit 0: accel_long_mg, accel_lat_mg, primary_speed_valid,
  // primary_speed_dkmh, backup_speed_valid, backup_speed_dkmh, event_type,
  // idle_seconds, zero fill.
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // Fields from bit 0: kind.
  logic [KIND_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // Fields from bit 0: score_centipoints, the six counters, idle_total_seconds,
  // detected_flags, zero fill.
  logic [OUT_DATA_W-1:0] m_tdata;

  // Shadow of the block's thresholds and state.
  logic [THR_W-1:0]      thr_brake = BRAKE_THR_RST;
  logic [THR_W-1:0]      thr_accel = ACCEL_THR_RST;
  logic [THR_W-1:0]      thr_corner = CORNER_THR_RST;
  logic [SPD_W-1:0]      thr_over = OVER_THR_RST;
  logic [COND_W-1:0]     prev_cond = '0;
  logic [OUT_CNT_W-1:0]  hit_count [NUM_CNT];
  logic [OUT_IDLE_W-1:0] idle_total = '0;
  logic [SCORE_W-1:0]    score_latch = SCORE_FULL;

  word_t   pending_words [$];
  report_t expected_reports [$];
  word_t   cur_word;
  report_t want, got;
  logic    word_taken = 1'b0;
  int      words_queued = 0;
  int      words_accepted = 0;
  int      mismatches = 0;
  int      quiet_cycles = 0;
  int      send_gap_pct = 0;
  int      recv_stall_pct = 0;
  int      hold_requests = 0;
  int      holds_begun = 0;
  int      hold_left = 0;

  harsh_event_detect_and_score DUT (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NUM_CNT; i++) begin
      hit_count[i] = '0;
    end
  end

  // Saturating increment of one event counter.
  function automatic void bump_count(input int slot);
    if (hit_count[slot] != '1) begin
      hit_count[slot] = hit_count[slot] + 1'b1;
    end
  endfunction

  // Advances the shadow state by one accepted word and returns its report.
  function automatic report_t predict_report(input word_t w);
    int                  along;
    int                  alat;
    logic [SPD_W-1:0]    speed;
    logic [COND_W-1:0]   now_cond;
    logic [COND_W-1:0]   rise;
    logic [OUT_IDLE_W:0] idle_sum;
    longint unsigned     penalty;
    report_t             r;
    rise = '0;
    case (w.kind)
      KIND_SAMPLE: begin
        along = int'($signed(w.f.accel_long));
        alat = int'($signed(w.f.accel_lat));
        speed = w.f.primary_valid ? w.f.primary_speed : w.f.backup_speed;
        now_cond = '0;
        if (along <= -int'(thr_brake)) now_cond[0] = 1'b1;
        if (along >= int'(thr_accel)) now_cond[1] = 1'b1;
        if (alat >= int'(thr_corner) || alat <= -int'(thr_corner)) now_cond[2] = 1'b1;
        if ((w.f.primary_valid || w.f.backup_valid) && speed >= thr_over) begin
          now_cond[3] = 1'b1;
        end
        // Only a condition that was false on the previous sample counts.
        rise = now_cond & ~prev_cond;
        if (rise[0]) bump_count(CNT_BRAKE);
        if (rise[1]) bump_count(CNT_ACCEL);
        if (rise[2]) bump_count(CNT_CORNER);
        if (rise[3]) bump_count(CNT_OVER);
        prev_cond = now_cond;
      end
      KIND_EVENT: begin
        case (w.f.event_type)
          EVT_BRAKE:    bump_count(CNT_BRAKE);
          EVT_ACCEL:    bump_count(CNT_ACCEL);
          EVT_CORNER:   bump_count(CNT_CORNER);
          EVT_OVER:     bump_count(CNT_OVER);
          EVT_CRASH:    bump_count(CNT_CRASH);
          EVT_GEOFENCE: bump_count(CNT_GEO);
          EVT_IDLING: begin
            idle_sum = {1'b0, idle_total} + (OUT_IDLE_W+1)'(w.f.idle_seconds);
            idle_total = idle_sum[OUT_IDLE_W] ? '1 : idle_sum[OUT_IDLE_W-1:0];
          end
          default: ;
        endcase
      end
      KIND_RECOMPUTE: begin
        penalty = 64'(idle_total / 32'd12);
        for (int i = 0; i < NUM_CNT; i++) begin
          penalty += 64'(CNT_WEIGHT[i]) * 64'(hit_count[i]);
        end
        score_latch = (penalty >= 64'(SCORE_FULL)) ? '0 :
                      SCORE_W'(64'(SCORE_FULL) - penalty);
      end
      default: ;
    endcase
    r.score = score_latch;
    for (int i = 0; i < NUM_CNT; i++) begin
      r.count[i] = hit_count[i];
    end
    r.idle_total = idle_total;
    r.flags = rise;
    return r;
  endfunction

  // Builds a random word. Gentle words rarely cross a threshold and never
  // report a crash, so the score walks down slowly.
  function automatic word_t random_word(input bit gentle);
    word_t w;
    int    pick;
    int    span;
    w.f.accel_long = ACC_W'($urandom());
    w.f.accel_lat = ACC_W'($urandom());
    w.f.primary_valid = 1'($urandom_range(1));
    w.f.primary_speed = SPD_W'($urandom());
    w.f.backup_valid = 1'($urandom_range(1));
    w.f.backup_speed = SPD_W'($urandom());
    w.f.event_type = EVT_W'($urandom());
    w.f.idle_seconds = SECS_W'($urandom());
    pick = $urandom_range(99);
    if (gentle) begin
      w.kind = (pick < 80) ? KIND_SAMPLE : (pick < 93) ? KIND_RECOMPUTE :
               (pick < 97) ? KIND_EVENT : KIND_NOP;
    end else begin
      w.kind = (pick < 55) ? KIND_SAMPLE : (pick < 80) ? KIND_EVENT :
               (pick < 95) ? KIND_RECOMPUTE : KIND_NOP;
    end
    span = gentle ? 15 : 3;
    if (w.kind == KIND_SAMPLE) begin
      // Values right at the thresholds make conditions rise and fall.
      case ($urandom_range(span))
        0: ;
        1: w.f.accel_long = ACC_W'(-int'(thr_brake) + int'($urandom_range(2)) - 1);
        2: w.f.accel_long = ACC_W'(int'(thr_accel) + int'($urandom_range(2)) - 1);
        default: w.f.accel_long = ACC_W'(int'($urandom_range(800)) - 400);
      endcase
      case ($urandom_range(span))
        0: ;
        1: w.f.accel_lat = ACC_W'(int'(thr_corner) + int'($urandom_range(2)) - 1);
        2: w.f.accel_lat = ACC_W'(-int'(thr_corner) + int'($urandom_range(2)) - 1);
        default: w.f.accel_lat = ACC_W'(int'($urandom_range(800)) - 400);
      endcase
      case ($urandom_range(span))
        0: ;
        1: w.f.primary_speed = SPD_W'(int'(thr_over) + int'($urandom_range(2)) - 1);
        default: w.f.primary_speed = SPD_W'($urandom_range(4000));
      endcase
      case ($urandom_range(span))
        0: ;
        1: w.f.backup_speed = SPD_W'(int'(thr_over) + int'($urandom_range(2)) - 1);
        default: w.f.backup_speed = SPD_W'($urandom_range(4000));
      endcase
    end else if (w.kind == KIND_EVENT && gentle) begin
      if (w.f.event_type == EVT_CRASH) w.f.event_type = EVT_UNKNOWN;
      w.f.idle_seconds = SECS_W'($urandom_range(120));
    end
    return w;
  endfunction

  task automatic queue_word(input word_t w);
    pending_words.push_back(w);
    words_queued++;
  endtask

  task automatic push_sample(input int along, input int alat, input bit pv, input int ps,
                             input bit bv, input int bs);
    word_t w;
    w = random_word(1'b0);
    w.kind = KIND_SAMPLE;
    w.f.accel_long = ACC_W'(along);
    w.f.accel_lat = ACC_W'(alat);
    w.f.primary_valid = pv;
    w.f.primary_speed = SPD_W'(ps);
    w.f.backup_valid = bv;
    w.f.backup_speed = SPD_W'(bs);
    queue_word(w);
  endtask

  task automatic push_event(input logic [EVT_W-1:0] evt, input logic [SECS_W-1:0] secs);
    word_t w;
    w = random_word(1'b0);
    w.kind = KIND_EVENT;
    w.f.event_type = evt;
    w.f.idle_seconds = secs;
    queue_word(w);
  endtask

  task automatic push_plain(input logic [KIND_W-1:0] kind);
    word_t w;
    w = random_word(1'b0);
    w.kind = kind;
    queue_word(w);
  endtask

  // Waits until every queued word has been taken and answered.
  task automatic wait_drained();
    do @(negedge clk);
    while (words_accepted != words_queued || expected_reports.size() != 0);
  endtask

  // One APB write: setup cycle, then access cycle.
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BRAKE_THR:  thr_brake = value[THR_W-1:0];
      REG_ACCEL_THR:  thr_accel = value[THR_W-1:0];
      REG_CORNER_THR: thr_corner = value[THR_W-1:0];
      REG_OVER_THR:   thr_over = value[SPD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_thresholds(input logic [31:0] brake, input logic [31:0] accel,
                                  input logic [31:0] corner, input logic [31:0] over);
    write_reg(REG_BRAKE_THR, brake);
    write_reg(REG_ACCEL_THR, accel);
    write_reg(REG_CORNER_THR, corner);
    write_reg(REG_OVER_THR, over);
  endtask

  // Random threshold with junk in the bits above the register width.
  function automatic logic [31:0] junk_threshold(input int top);
    return ($urandom() & ~32'h3FFF) | $urandom_range(top);
  endfunction

  task automatic run_phase(input bit gentle, input int count, input int gap, input int stall,
                           input bit long_hold);
    send_gap_pct = gap;
    recv_stall_pct = stall;
    repeat (count) queue_word(random_word(gentle));
    if (long_hold) hold_requests++;
    wait_drained();
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_val,
                             input logic [31:0] act_val);
    if (exp_val !== act_val) begin
      mismatches++;
      $display("%0t: %s expected %0d actual %0d", $time, what, exp_val, act_val);
    end
  endtask

  // Driver: presents the next pending word once the current one is taken.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || word_taken) begin
      if (pending_words.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
        cur_word = pending_words.pop_front();
        s_tdata <= IN_DATA_W'(cur_word.f);
        s_tuser <= cur_word.kind;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_begun != hold_requests) begin
      m_tready <= 1'b0;
      hold_left <= LONG_HOLD;
      holds_begun <= holds_begun + 1;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on each accepted word, checks each result word, and
  // ends the run when nothing moves for too long.
  always @(posedge clk) begin
    word_taken <= !rst && s_tvalid && s_tready;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_reports.push_back(predict_report(cur_word));
        words_accepted++;
      end
      if (m_tvalid && m_tready) begin
        if (expected_reports.size() == 0) begin
          mismatches++;
          $display("%0t: result word expected none actual %h", $time, m_tdata);
        end else begin
          want = expected_reports.pop_front();
          got = m_tdata[OUT_USED_W-1:0];
          check_field("score", 32'(want.score), 32'(got.score));
          for (int i = 0; i < NUM_CNT; i++) begin
            check_field($sformatf("counter %0d", i), 32'(want.count[i]),
                        32'(got.count[i]));
          end
          check_field("idle total", want.idle_total, got.idle_total);
          check_field("detected flags", 32'(want.flags), 32'(got.flags));
          check_field("zero fill", '0, 32'(m_tdata >> OUT_USED_W));
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Stimulus sequence.
  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed words at the reset thresholds.
    push_plain(KIND_NOP);
    push_plain(KIND_RECOMPUTE);
    // Braking exactly at the threshold; primary speed wins over backup.
    push_sample(-400, 0, 1'b1, 1199, 1'b1, 4095);
    // Same condition held: no new count.
    push_sample(-400, 0, 1'b1, 1199, 1'b1, 4095);
    // Acceleration and cornering at the threshold; backup speed used.
    push_sample(400, -400, 1'b0, 0, 1'b1, 1200);
    // Field extremes; no valid speed means no overspeed.
    push_sample(-16384, 16383, 1'b0, 4095, 1'b0, 4095);
    push_sample(16383, -16384, 1'b1, 4095, 1'b0, 0);
    push_sample(-399, 399, 1'b1, 0, 1'b1, 4095);
    push_plain(KIND_RECOMPUTE);
    push_event(EVT_BRAKE, '1);
    push_event(EVT_ACCEL, '0);
    push_event(EVT_CORNER, '1);
    push_event(EVT_OVER, '0);
    push_event(EVT_IDLING, '0);
    push_event(EVT_IDLING, SECS_W'(23));
    push_event(EVT_GEOFENCE, '1);
    push_event(EVT_UNKNOWN, '1);
    push_event(EVT_CRASH, '0);
    push_plain(KIND_RECOMPUTE);
    push_plain(KIND_NOP);
    wait_drained();

    // Thresholds at their maximum (upper bits set) let the score walk down.
    write_thresholds('1, '1, '1, '1);
    run_phase(1'b1, 250, 0, 0, 1'b1);
    write_thresholds('0, '0, '0, '0);
    run_phase(1'b0, 250, 69, 0, 1'b0);
    write_thresholds(junk_threshold(2000), junk_threshold(2000), junk_threshold(2000),
                     junk_threshold(4095));
    run_phase(1'b0, 260, 0, 69, 1'b0);
    write_thresholds(junk_threshold(16383), junk_threshold(1000), junk_threshold(3000),
                     junk_threshold(2000));
    run_phase(1'b0, 260, 32, 32, 1'b0);
    write_thresholds(32'(BRAKE_THR_RST), 32'(ACCEL_THR_RST), 32'(CORNER_THR_RST),
                     32'(OVER_THR_RST));
    run_phase(1'b0, 260, 0, 0, 1'b1);
    write_thresholds(junk_threshold(800), junk_threshold(800), junk_threshold(800),
                     junk_threshold(1500));
    run_phase(1'b0, 270, 32, 32, 1'b0);

    // A short closing burst with no send gaps or receive stalls.
    run_phase(1'b0, 40, 0, 0, 1'b0);

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
